@@ src/fllc_pkg.sv @@
// Shared constants, types and helper functions for the fault latch lamp controller.
package fllc_pkg;

  // Number of fault bits that are latched.
  localparam int FAULT_BITS = 8;
  localparam int COUNT_W    = $clog2(FAULT_BITS + 1);
  localparam int OP_W       = 3;
  localparam int PERIOD_W   = 16;
  localparam int PATTERN_W  = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  typedef logic [FAULT_BITS-1:0] fault_mask_t;
  typedef logic [COUNT_W-1:0]    fault_count_t;
  typedef logic [OP_W-1:0]       op_code_t;
  typedef logic [PERIOD_W-1:0]   period_t;
  typedef logic [PATTERN_W-1:0]  pattern_t;
  typedef logic [CFG_IDX_W-1:0]  cfg_index_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  // Operation codes of an input word.
  localparam op_code_t OP_SET       = 3'd0;
  localparam op_code_t OP_CLEAR     = 3'd1;
  localparam op_code_t OP_ACK       = 3'd2;
  localparam op_code_t OP_CLEAR_ALL = 3'd3;
  localparam op_code_t OP_TICK      = 3'd4;

  // Lamp patterns.
  localparam pattern_t PAT_OFF   = 2'd0;
  localparam pattern_t PAT_SOLID = 2'd1;
  localparam pattern_t PAT_SLOW  = 2'd2;
  localparam pattern_t PAT_FAST  = 2'd3;

  // Configuration register indexes.
  localparam cfg_index_t CFG_CRITICAL_MASK = 2'd0;
  localparam cfg_index_t CFG_SLOW_PERIOD   = 2'd1;
  localparam cfg_index_t CFG_FAST_PERIOD   = 2'd2;

  // Reset values of the blink periods in milliseconds.
  localparam period_t SLOW_PERIOD_RESET = 16'd2000;
  localparam period_t FAST_PERIOD_RESET = 16'd500;
  localparam period_t SINCE_MAX         = '1;

  // Number of set bits in a fault mask.
  function automatic fault_count_t count_faults(input fault_mask_t mask);
    fault_count_t n;
    n = '0;
    for (int i = 0; i < FAULT_BITS; i++) begin
      n = n + fault_count_t'(mask[i]);
    end
    return n;
  endfunction

  // Lamp pattern chosen from the fault masks.
  function automatic pattern_t choose_pattern(input fault_mask_t active,
                                              input fault_mask_t acked,
                                              input fault_mask_t critical);
    fault_mask_t unacked;
    pattern_t    pat;
    unacked = active & ~acked;
    if (active == '0) begin
      pat = PAT_OFF;
    end else if ((active & critical) != '0) begin
      pat = PAT_FAST;
    end else if (unacked != '0 && count_faults(unacked) == fault_count_t'(1)) begin
      pat = PAT_SOLID;
    end else begin
      pat = PAT_SLOW;
    end
    return pat;
  endfunction

endpackage

@@ src/fault_latch_lamp_controller.sv @@
// Top level of the fault latch lamp controller: input register, update logic, result register.
//
// Every input word (set, clear, acknowledge, clear all or a one-millisecond tick) yields
// exactly one result word reporting the lamp level, stable LED, pattern, fault masks and
// counts after that word. The block takes one word per cycle while the input is not stalled:
// a word waits in the input register, its fault and lamp state update is one short pass of
// logic, and the result register holds it until taken. A word accepted into the input
// register has its result loaded into the result register once it is free or being emptied.
// The input stalls only while both the input register and the result register are occupied
// and the result is stalled. Configuration writes are registered and should be made while
// no word is in flight.
module fault_latch_lamp_controller (
  input  logic                     clk,
  input  logic                     rst,
  // Configuration write port.
  input  logic                     cfg_write,
  input  fllc_pkg::cfg_index_t     cfg_index,
  input  fllc_pkg::cfg_data_t      cfg_data,
  // Input channel.
  input  logic                     in_valid,
  output logic                     in_stall,
  input  fllc_pkg::op_code_t       op,
  input  fllc_pkg::fault_mask_t    fault_bits,
  // Result channel.
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     lamp_on,
  output logic                     stable_led_on,
  output fllc_pkg::pattern_t       pattern,
  output fllc_pkg::fault_mask_t    active_faults,
  output fllc_pkg::fault_mask_t    acked_faults,
  output fllc_pkg::fault_count_t   active_count,
  output fllc_pkg::fault_count_t   unacked_count,
  output logic                     lamp_changed
);
  import fllc_pkg::*;

  // Configuration registers.
  fault_mask_t critical_mask;
  period_t     slow_period_ms;
  period_t     fast_period_ms;

  // Input register.
  logic        s1_valid;
  op_code_t    s1_op;
  fault_mask_t s1_bits;

  // Controller state.
  fault_mask_t active_mask, active_mask_next;
  fault_mask_t ack_mask, ack_mask_next;
  logic        lamp_level, lamp_level_next;
  logic        stable_level, stable_level_next;
  period_t     since_toggle_ms, since_toggle_ms_next;

  logic        advance;
  logic        do_refresh;
  period_t     since_counted;
  period_t     period;
  pattern_t    pattern_next;

  // The input register moves on when the result register is free or being emptied.
  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      critical_mask  <= '0;
      slow_period_ms <= SLOW_PERIOD_RESET;
      fast_period_ms <= FAST_PERIOD_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_CRITICAL_MASK: critical_mask  <= cfg_data[FAULT_BITS-1:0];
        CFG_SLOW_PERIOD:   slow_period_ms <= cfg_data[PERIOD_W-1:0];
        CFG_FAST_PERIOD:   fast_period_ms <= cfg_data[PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register capture.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_op   <= op;
      s1_bits <= fault_bits;
    end
  end

  // Mask update for the word in the input register.
  always_comb begin
    active_mask_next = active_mask;
    ack_mask_next    = ack_mask;
    since_counted    = since_toggle_ms;
    do_refresh       = 1'b0;
    case (s1_op)
      OP_SET: begin
        active_mask_next = active_mask | s1_bits;
        do_refresh       = 1'b1;
      end
      OP_CLEAR: begin
        if ((active_mask & s1_bits) != '0) begin
          active_mask_next = active_mask & ~s1_bits;
          ack_mask_next    = ack_mask & ~s1_bits;
          do_refresh       = 1'b1;
        end
      end
      OP_ACK: begin
        if ((active_mask & s1_bits) != '0) begin
          ack_mask_next = ack_mask | (s1_bits & active_mask);
          do_refresh    = 1'b1;
        end
      end
      OP_CLEAR_ALL: begin
        if (active_mask != '0) begin
          active_mask_next = '0;
          ack_mask_next    = '0;
          do_refresh       = 1'b1;
        end
      end
      OP_TICK: begin
        if (since_toggle_ms != SINCE_MAX) begin
          since_counted = since_toggle_ms + period_t'(1);
        end
        do_refresh = 1'b1;
      end
      default: ;
    endcase
  end

  // Indicator refresh from the updated masks.
  always_comb begin
    pattern_next         = choose_pattern(active_mask_next, ack_mask_next, critical_mask);
    period               = (pattern_next == PAT_SLOW) ? slow_period_ms : fast_period_ms;
    lamp_level_next      = lamp_level;
    stable_level_next    = stable_level;
    since_toggle_ms_next = since_counted;
    if (do_refresh) begin
      stable_level_next = (active_mask_next == '0);
      case (pattern_next)
        PAT_OFF:   lamp_level_next = 1'b0;
        PAT_SOLID: lamp_level_next = 1'b1;
        default: begin
          if (since_counted >= period) begin
            lamp_level_next      = !lamp_level;
            since_toggle_ms_next = '0;
          end
        end
      endcase
    end
  end

  // State update.
  always_ff @(posedge clk) begin
    if (rst) begin
      active_mask     <= '0;
      ack_mask        <= '0;
      lamp_level      <= 1'b0;
      stable_level    <= 1'b0;
      since_toggle_ms <= '0;
    end else if (advance) begin
      active_mask     <= active_mask_next;
      ack_mask        <= ack_mask_next;
      lamp_level      <= lamp_level_next;
      stable_level    <= stable_level_next;
      since_toggle_ms <= since_toggle_ms_next;
    end
  end

  // Result register valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Result register payload.
  always_ff @(posedge clk) begin
    if (advance) begin
      lamp_on       <= lamp_level_next;
      stable_led_on <= stable_level_next;
      pattern       <= pattern_next;
      active_faults <= active_mask_next;
      acked_faults  <= ack_mask_next;
      active_count  <= count_faults(active_mask_next);
      unacked_count <= count_faults(active_mask_next & ~ack_mask_next);
      lamp_changed  <= (lamp_level_next != lamp_level);
    end
  end

endmodule
